/* design/srr_pkg.sv */
// ----------------------------------------------------------------------------
// Stepper rate and ramp package
// Shared widths and the handshake structs between the sequencer and the
// serial divider.
// ----------------------------------------------------------------------------
package srr_pkg;

  localparam int DVD_W = 20;
  localparam int DVS_W = 16;

  typedef enum logic [1:0] {
    PRES_64   = 2'd0,
    PRES_256  = 2'd1,
    PRES_1024 = 2'd2
  } pres_code_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* design/srr_div.sv */
// ----------------------------------------------------------------------------
// Stepper rate serial divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  srr_pkg::div_ctrl_t        ctrl_i,
  input  logic [srr_pkg::DVD_W-1:0] dividend_i,
  input  logic [srr_pkg::DVS_W-1:0] divisor_i,
  output logic [srr_pkg::DVD_W-1:0] quotient_o,
  output srr_pkg::div_stat_t        stat_o
);
  import srr_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W:0]   rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign rem_sh = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
  assign trial  = rem_sh - {1'b0, dvs_q};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial : rem_sh;
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

/* design/stepper_rate_and_ramp_unit.sv */
// Order: a timer-expiry beat with nonzero speed passes prepare, the 20-step bit-serial
// period divider, period and finish; zero speed skips the divider, a ramp tick passes
// the pan and tilt ramp states and finish, and a too-early ramp tick skips the tilt ramp state.
// One beat in flight; the next beat is accepted only after the result is registered and
// the sequencer is back in idle, and an unaccepted older result stalls it.
// Reset clears speeds, prescalers and the elapsed counter and sets the tilt period to 255.
// ----------------------------------------------------------------------------
// Stepper rate and ramp unit
// Two-axis step-rate generator with a linear speed ramp, built around a
// small sequencer, one serial divider and one shared ramp stepper.
// ----------------------------------------------------------------------------
module stepper_rate_and_ramp_unit #(
  parameter int BASE_CLOCK_HZ = 16000000,
  parameter int RAMP_RATE_HZ  = 50
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic               axis_i,
  input  logic signed [15:0] goal_pan_i,
  input  logic signed [15:0] goal_tilt_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_axis_o,
  output logic               step_pulse_o,
  output logic               direction_o,
  output logic [1:0]         prescaler_code_o,
  output logic [7:0]         period_count_o,
  output logic               ramp_applied_o,
  output logic signed [15:0] speed_pan_out_o,
  output logic signed [15:0] speed_tilt_out_o
);
  import srr_pkg::*;

  localparam logic [31:0] TH_64  = 32'(BASE_CLOCK_HZ / 256 / 64);
  localparam logic [31:0] TH_256 = 32'(BASE_CLOCK_HZ / 256 / 256);
  localparam logic [31:0] NEED   = 32'(BASE_CLOCK_HZ / RAMP_RATE_HZ);
  localparam logic [DVD_W-1:0] DVD_64   = DVD_W'(BASE_CLOCK_HZ / 64);
  localparam logic [DVD_W-1:0] DVD_256  = DVD_W'(BASE_CLOCK_HZ / 256);
  localparam logic [DVD_W-1:0] DVD_1024 = DVD_W'(BASE_CLOCK_HZ / 1024);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_PREP      = 3'd1;
  localparam logic [2:0] S_DIV       = 3'd2;
  localparam logic [2:0] S_PERIOD    = 3'd3;
  localparam logic [2:0] S_RAMP_PAN  = 3'd4;
  localparam logic [2:0] S_RAMP_TILT = 3'd5;
  localparam logic [2:0] S_FIN       = 3'd6;

  logic [2:0]         state_q;
  logic [14:0]        accel_q [2];
  logic signed [15:0] speed_q [2];
  logic [10:0]        pres_q [2];
  logic [7:0]         tilt_period_q;
  logic [31:0]        elapsed_q;

  logic               func_q;
  logic               ax_q;
  logic signed [15:0] goal_q [2];
  logic [15:0]        mag_q;
  pres_code_e         code_q;
  logic               neg_q;
  logic [7:0]         period_q;
  logic               applied_q;

  logic               out_valid_q;
  logic               o_axis_q;
  logic               o_step_q;
  logic               o_dir_q;
  logic [1:0]         o_code_q;
  logic [7:0]         o_period_q;
  logic               o_applied_q;
  logic signed [15:0] o_spd_pan_q;
  logic signed [15:0] o_spd_tilt_q;

  logic signed [15:0] spd;
  logic [15:0]        mag;
  pres_code_e         code;
  logic [10:0]        pres_val;
  logic [18:0]        prod;
  logic [32:0]        sum;
  logic [DVD_W-1:0]   dividend;
  logic [DVD_W-1:0]   quotient;
  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic               ramp_ax;
  logic signed [15:0] ramp_next;
  logic               cfg_wr;
  logic               fin_go;

  function automatic logic signed [15:0] ramp_axis(logic signed [15:0] cur,
                                                   logic signed [15:0] goal_raw,
                                                   logic [14:0] accel);
    logic signed [16:0] goal;
    logic signed [16:0] acc;
    logic signed [16:0] diff;
    logic signed [16:0] nxt;
    goal = (goal_raw == 16'sh8000) ? -17'sd32767 : 17'(goal_raw);
    acc  = $signed({2'b00, accel});
    diff = goal - 17'(cur);
    if (diff > -acc && diff < acc) begin
      nxt = goal;
    end else if (diff > 17'sd0) begin
      nxt = 17'(cur) + acc;
    end else begin
      nxt = 17'(cur) - acc;
    end
    if (nxt > 17'sd32767) begin
      nxt = 17'sd32767;
    end else if (nxt < -17'sd32767) begin
      nxt = -17'sd32767;
    end
    return nxt[15:0];
  endfunction

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {17'd0, accel_q[paddr[2]]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q[0] <= '0;
      accel_q[1] <= '0;
    end else if (cfg_wr) begin
      accel_q[paddr[2]] <= pwdata[14:0];
    end
  end

  assign spd = speed_q[ax_q];
  assign mag = spd[15] ? 16'(-spd) : 16'(spd);

  always_comb begin
    if ({16'd0, mag} >= TH_64) begin
      code     = PRES_64;
      pres_val = 11'd64;
      dividend = DVD_64;
    end else if ({16'd0, mag} >= TH_256) begin
      code     = PRES_256;
      pres_val = 11'd256;
      dividend = DVD_256;
    end else begin
      code     = PRES_1024;
      pres_val = 11'd1024;
      dividend = DVD_1024;
    end
  end

  assign prod = {11'd0, tilt_period_q} * {8'd0, pres_q[1]};
  assign sum  = {1'b0, elapsed_q} + {14'd0, prod};

  assign div_ctrl.start = (state_q == S_PREP) && (mag != 16'd0);

  srr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (dividend),
    .divisor_i  (mag),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  assign ramp_ax   = (state_q == S_RAMP_TILT);
  assign ramp_next = ramp_axis(speed_q[ramp_ax], goal_q[ramp_ax], accel_q[ramp_ax]);

  assign fin_go = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      speed_q[0]    <= '0;
      speed_q[1]    <= '0;
      pres_q[0]     <= '0;
      pres_q[1]     <= '0;
      tilt_period_q <= 8'd255;
      elapsed_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= func_i ? S_RAMP_PAN : S_PREP;
          end
        end
        S_PREP: begin
          if (ax_q) begin
            elapsed_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          end
          pres_q[ax_q] <= pres_val;
          state_q      <= (mag != 16'd0) ? S_DIV : S_PERIOD;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_q <= S_PERIOD;
          end
        end
        S_PERIOD: begin
          if (ax_q) begin
            tilt_period_q <= period_q;
          end
          state_q <= S_FIN;
        end
        S_RAMP_PAN: begin
          if (elapsed_q >= NEED) begin
            elapsed_q  <= elapsed_q - NEED;
            speed_q[0] <= ramp_next;
            state_q    <= S_RAMP_TILT;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_RAMP_TILT: begin
          speed_q[1] <= ramp_next;
          state_q    <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      func_q    <= func_i;
      ax_q      <= axis_i;
      goal_q[0] <= goal_pan_i;
      goal_q[1] <= goal_tilt_i;
      applied_q <= 1'b0;
      period_q  <= 8'd255;
    end
    if (state_q == S_PREP) begin
      mag_q  <= mag;
      code_q <= code;
      neg_q  <= spd[15];
    end
    if (state_q == S_DIV && div_stat.done) begin
      if (quotient > DVD_W'(255)) begin
        period_q <= 8'd255;
      end else if (quotient == '0) begin
        period_q <= 8'd1;
      end else begin
        period_q <= quotient[7:0];
      end
    end
    if (state_q == S_RAMP_PAN && elapsed_q >= NEED) begin
      applied_q <= 1'b1;
    end
    if (fin_go) begin
      o_axis_q     <= !func_q && ax_q;
      o_step_q     <= !func_q && (mag_q != 16'd0);
      o_dir_q      <= !func_q && neg_q;
      o_code_q     <= func_q ? 2'd0 : code_q;
      o_period_q   <= func_q ? 8'd0 : period_q;
      o_applied_q  <= func_q && applied_q;
      o_spd_pan_q  <= speed_q[0];
      o_spd_tilt_q <= speed_q[1];
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign out_axis_o       = o_axis_q;
  assign step_pulse_o     = o_step_q;
  assign direction_o      = o_dir_q;
  assign prescaler_code_o = o_code_q;
  assign period_count_o   = o_period_q;
  assign ramp_applied_o   = o_applied_q;
  assign speed_pan_out_o  = o_spd_pan_q;
  assign speed_tilt_out_o = o_spd_tilt_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("accepted a second beat while busy");

  a_ramp_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ramp_applied_o) |-> (!step_pulse_o && period_count_o == 8'd0))
    else $error("ramp result carries timer fields");

  a_step_has_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && step_pulse_o) |-> (period_count_o != 8'd0 && prescaler_code_o != 2'd3))
    else $error("step issued without a valid period");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (speed_q[0] != 16'sh8000) && (speed_q[1] != 16'sh8000))
    else $error("speed left the saturation range");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide phase");

endmodule
